// ===== hdl/logi_pkg.sv =====
// ----------------------------------------------------------------------------
// logi_pkg
// Shared types and constants of the local obstacle grid inflation unit:
// command and status codes, register indexes and word layouts.
// ----------------------------------------------------------------------------
package logi_pkg;

   // command codes carried in req_tuser
   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_LOAD   = 2'd1,
      CMD_INSERT = 2'd2,
      CMD_QUERY  = 2'd3
   } cmd_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_BOUNDS  = 2'd1,
      ST_HEIGHT  = 2'd2,
      ST_BLOCKED = 2'd3
   } status_type;

   // configuration register indexes
   typedef enum logic [2:0] {
      REG_ORIGIN_X  = 3'd0,
      REG_ORIGIN_Y  = 3'd1,
      REG_INV_RES   = 3'd2,
      REG_Z_LOW     = 3'd3,
      REG_Z_HIGH    = 3'd4,
      REG_THRESHOLD = 3'd5,
      REG_SWELL     = 3'd6
   } reg_index_type;

   localparam int REQ_W = 72;
   localparam int RSP_W = 8;

   // result word layout: status in [1:0], then the query flags
   localparam int RSP_OCC_BIT  = 2;
   localparam int RSP_LOC_BIT  = 3;
   localparam int RSP_FREE_BIT = 4;

   // 1.0 m in Q8.8
   localparam logic signed [17:0] ONE_METRE = 18'sd256;

endpackage

// ===== hdl/logi_ram.sv =====
// ----------------------------------------------------------------------------
// logi_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered, valid the cycle after the read address is presented.
// ----------------------------------------------------------------------------
module logi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/local_obstacle_grid_inflation_unit.sv =====
// ----------------------------------------------------------------------------
// local_obstacle_grid_inflation_unit
// Occupancy grid with obstacle inflation. Flags live in a row-wide memory
// (bridge, global, local bits of one grid row per word), ground heights in
// a per-cell memory. Commands are handled one at a time by a sequencer that
// reads, modifies and writes back whole rows.
// ----------------------------------------------------------------------------
// Path from accept to rsp_tvalid: load and out-of-bounds rejects via S_MUL,
//   S_CHK, S_OUT; query and height or occupancy rejected insert add S_RD;
//   accepted insert adds S_RD, S_INF over the inflated rows (2*swell+1,
//   grid-clipped); clear is S_INF over all rows; input reopens with rsp_tvalid.
// Inflation and clear cost one cycle per row on the flag memory ports.
// Reset: synchronous; an S_INIT sweep over all rows zeroes the flag memory with
//   req_tready low. Heights are not cleared and stay undefined until loaded.

module local_obstacle_grid_inflation_unit
   import logi_pkg::*;
#(
   parameter int GRID_X    = 256,
   parameter int GRID_Y    = 256,
   parameter int MAX_SWELL = 8
) (
   input  logic              clock,
   input  logic              reset,
   // x[15:0], y[31:16], z[47:32], global_obstacle[48], bridge_flag[49],
   // query_x[57:50], query_y[65:58], zero pad[71:66]
   input  logic [REQ_W-1:0]  req_tdata,
   // command[1:0]
   input  logic [1:0]        req_tuser,
   input  logic              req_tvalid,
   output logic              req_tready,
   // status[1:0], occupied[2], local_occupied[3], cell_free[4], zero pad[7:5]
   output logic [RSP_W-1:0]  rsp_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic              csr_wr_en,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_wdata
);

   localparam int XW     = $clog2(GRID_X);
   localparam int YW     = $clog2(GRID_Y);
   localparam int XE     = ((XW > 4) ? XW : 4) + 1;
   localparam int YE     = ((YW > 4) ? YW : 4) + 1;
   localparam int WW     = 3 * GRID_Y;
   localparam int HDEPTH = GRID_X * (2 ** YW);

   typedef enum logic [2:0] {
      S_INIT, S_IDLE, S_MUL, S_CHK, S_RD, S_INF, S_OUT
   } state_type;

   // configuration registers
   logic signed [15:0] origin_x_ff, origin_y_ff, z_low_ff, z_high_ff;
   logic [15:0]        inv_res_ff;
   logic [14:0]        thr_ff;
   logic [3:0]         swell_ff;

   // sequencer and item registers
   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic signed [15:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic               gflag_ff, gflag_in, bflag_ff, bflag_in;
   logic [7:0]         qx_ff, qx_in, qy_ff, qy_in;
   logic               negx_ff, negx_in, negy_ff, negy_in;
   logic [15:0]        cellx_ff, cellx_in, celly_ff, celly_in;
   logic [YW-1:0]      iy_ff, iy_in;
   logic [XW-1:0]      row_ff, row_in, hi_row_ff, hi_row_in;
   logic [WW-1:0]      and_mask_ff, and_mask_in, or_mask_ff, or_mask_in;
   status_type         status_ff, status_in;
   logic               occ_ff, occ_in, loc_ff, loc_in, free_ff, free_in;
   logic               rmw_vld_ff, rmw_vld_in;
   logic [XW-1:0]      rmw_row_ff, rmw_row_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_W-1:0]   rsp_tdata_ff, rsp_tdata_in;

   // memory ports
   logic               a_wr_en;
   logic [XW-1:0]      a_wr_addr, a_rd_addr;
   logic [WW-1:0]      a_wr_data, a_rd_data;
   logic               h_wr_en;
   logic [XW+YW-1:0]   h_addr;
   logic [15:0]        h_rd_data;

   // combinational helpers
   logic signed [16:0] dx, dy;
   logic [31:0]        prodx, prody;
   logic [3:0]         swell_eff;
   logic               oob, z_bad;
   logic [XW-1:0]      row_sel, lo_x, hi_x;
   logic [YW-1:0]      col_sel;
   logic [XE-1:0]      lo_xe, hi_xe;
   logic [YE-1:0]      lo_ye, hi_ye;
   logic [GRID_Y-1:0]  pt_bit, swell_row;
   logic [GRID_Y-1:0]  loc_row, glob_row, br_row;
   logic               loc_b, glob_b, br_b;
   logic signed [17:0] h_ext, thr_ext, z_ext;
   logic               h_bad;

   // flag rows: {bridge, global, local}
   logi_ram #(.WIDTH(WW), .DEPTH(GRID_X)) u_flag_ram (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (a_wr_addr),
      .wr_data (a_wr_data),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   // ground height per cell, address {row, column}
   logi_ram #(.WIDTH(16), .DEPTH(HDEPTH)) u_height_ram (
      .clock   (clock),
      .wr_en   (h_wr_en),
      .wr_addr (h_addr),
      .wr_data (cz_ff),
      .rd_addr (h_addr),
      .rd_data (h_rd_data)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         inv_res_ff  <= 16'd5120;
         z_low_ff    <= -16'sd512;
         z_high_ff   <= 16'sd768;
         thr_ff      <= 15'd26;
         swell_ff    <= 4'd2;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_ORIGIN_X:  origin_x_ff <= csr_wdata;
            REG_ORIGIN_Y:  origin_y_ff <= csr_wdata;
            REG_INV_RES:   inv_res_ff  <= csr_wdata;
            REG_Z_LOW:     z_low_ff    <= csr_wdata;
            REG_Z_HIGH:    z_high_ff   <= csr_wdata;
            REG_THRESHOLD: thr_ff      <= csr_wdata[14:0];
            REG_SWELL:     swell_ff    <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // coordinate to cell: (c - origin) * inv_res in Q16.16, whole cells
   always_comb begin
      dx       = {cx_ff[15], cx_ff} - {origin_x_ff[15], origin_x_ff};
      dy       = {cy_ff[15], cy_ff} - {origin_y_ff[15], origin_y_ff};
      prodx    = dx[15:0] * inv_res_ff;
      prody    = dy[15:0] * inv_res_ff;
      cellx_in = prodx[31:16];
      celly_in = prody[31:16];
      negx_in  = dx[16];
      negy_in  = dy[16];
   end

   // bounds, target cell and inflation window
   always_comb begin
      swell_eff = (32'(swell_ff) > MAX_SWELL) ? 4'(MAX_SWELL) : swell_ff;
      z_bad     = (cz_ff < z_low_ff) || (cz_ff >= z_high_ff);
      if (cmd_ff == CMD_QUERY) begin
         oob     = (17'(qx_ff) >= 17'(GRID_X)) || (17'(qy_ff) >= 17'(GRID_Y));
         row_sel = XW'(qx_ff);
         col_sel = YW'(qy_ff);
      end else begin
         oob     = negx_ff || negy_ff
                   || ({1'b0, cellx_ff} >= 17'(GRID_X))
                   || ({1'b0, celly_ff} >= 17'(GRID_Y))
                   || ((cmd_ff == CMD_INSERT) && z_bad);
         row_sel = cellx_ff[XW-1:0];
         col_sel = celly_ff[YW-1:0];
      end

      lo_xe = (XE'(row_sel) >= XE'(swell_eff)) ? XE'(row_sel) - XE'(swell_eff) : '0;
      hi_xe = XE'(row_sel) + XE'(swell_eff);
      lo_x  = lo_xe[XW-1:0];
      hi_x  = (hi_xe >= XE'(GRID_X - 1)) ? XW'(GRID_X - 1) : hi_xe[XW-1:0];
      lo_ye = (YE'(col_sel) >= YE'(swell_eff)) ? YE'(col_sel) - YE'(swell_eff) : '0;
      hi_ye = YE'(col_sel) + YE'(swell_eff);

      pt_bit = '0;
      pt_bit[col_sel] = 1'b1;
      for (int j = 0; j < GRID_Y; j++) begin
         swell_row[j] = (YE'(j) >= lo_ye) && (YE'(j) <= hi_ye);
      end
   end

   // row read-back checks
   always_comb begin
      loc_row  = a_rd_data[GRID_Y-1:0];
      glob_row = a_rd_data[2*GRID_Y-1:GRID_Y];
      br_row   = a_rd_data[3*GRID_Y-1:2*GRID_Y];
      loc_b    = loc_row[iy_ff];
      glob_b   = glob_row[iy_ff];
      br_b     = br_row[iy_ff];
      h_ext    = {{2{h_rd_data[15]}}, h_rd_data};
      thr_ext  = {3'b000, thr_ff};
      z_ext    = {{2{cz_ff[15]}}, cz_ff};
      h_bad    = (h_ext + thr_ext > z_ext) || (h_ext + ONE_METRE < z_ext);
   end

   // memory port steering
   always_comb begin
      a_rd_addr = (state_ff == S_CHK) ? row_sel : row_ff;
      h_addr    = {row_sel, col_sel};
      h_wr_en   = (state_ff == S_CHK) && (cmd_ff == CMD_LOAD) && !oob;
      if (state_ff == S_INIT) begin
         a_wr_en   = 1'b1;
         a_wr_addr = row_ff;
         a_wr_data = '0;
      end else begin
         a_wr_en   = rmw_vld_ff;
         a_wr_addr = rmw_row_ff;
         a_wr_data = (a_rd_data & and_mask_ff) | or_mask_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      cz_in         = cz_ff;
      gflag_in      = gflag_ff;
      bflag_in      = bflag_ff;
      qx_in         = qx_ff;
      qy_in         = qy_ff;
      iy_in         = iy_ff;
      row_in        = row_ff;
      hi_row_in     = hi_row_ff;
      and_mask_in   = and_mask_ff;
      or_mask_in    = or_mask_ff;
      status_in     = status_ff;
      occ_in        = occ_ff;
      loc_in        = loc_ff;
      free_in       = free_ff;
      rmw_vld_in    = 1'b0;
      rmw_row_in    = rmw_row_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;

      unique case (state_ff)
         S_INIT: begin
            row_in = row_ff + 1'b1;
            if (row_ff == XW'(GRID_X - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in    = cmd_type'(req_tuser);
               cx_in     = req_tdata[15:0];
               cy_in     = req_tdata[31:16];
               cz_in     = req_tdata[47:32];
               gflag_in  = req_tdata[48];
               bflag_in  = req_tdata[49];
               qx_in     = req_tdata[57:50];
               qy_in     = req_tdata[65:58];
               status_in = ST_DONE;
               occ_in    = 1'b0;
               loc_in    = 1'b0;
               free_in   = 1'b0;
               if (cmd_type'(req_tuser) == CMD_CLEAR) begin
                  // sweep every row, dropping the local bits
                  row_in      = '0;
                  hi_row_in   = XW'(GRID_X - 1);
                  and_mask_in = {{(2*GRID_Y){1'b1}}, {GRID_Y{1'b0}}};
                  or_mask_in  = '0;
                  state_in    = S_INF;
               end else begin
                  state_in = S_MUL;
               end
            end
         end

         S_MUL: begin
            state_in = S_CHK;
         end

         S_CHK: begin
            iy_in = col_sel;
            if (oob) begin
               status_in = ST_BOUNDS;
               state_in  = S_OUT;
            end else begin
               case (cmd_ff)
                  CMD_LOAD: begin
                     // height written now, flag row merged next cycle
                     and_mask_in = '1;
                     or_mask_in  = {({GRID_Y{bflag_ff}} & pt_bit),
                                    ({GRID_Y{gflag_ff}} & pt_bit), {GRID_Y{1'b0}}};
                     rmw_vld_in  = 1'b1;
                     rmw_row_in  = row_sel;
                     state_in    = S_OUT;
                  end
                  CMD_INSERT: begin
                     and_mask_in = '1;
                     or_mask_in  = {{(2*GRID_Y){1'b0}}, swell_row};
                     row_in      = lo_x;
                     hi_row_in   = hi_x;
                     state_in    = S_RD;
                  end
                  default: begin
                     state_in = S_RD;
                  end
               endcase
            end
         end

         S_RD: begin
            if (cmd_ff == CMD_QUERY) begin
               loc_in   = loc_b;
               occ_in   = glob_b || loc_b;
               free_in  = !(glob_b || loc_b);
               state_in = S_OUT;
            end else if (h_bad) begin
               status_in = ST_HEIGHT;
               state_in  = S_OUT;
            end else if (glob_b || loc_b || br_b) begin
               status_in = ST_BLOCKED;
               state_in  = S_OUT;
            end else begin
               state_in = S_INF;
            end
         end

         S_INF: begin
            // one row read per cycle, written back the cycle after
            rmw_vld_in = 1'b1;
            rmw_row_in = row_ff;
            row_in     = row_ff + 1'b1;
            if (row_ff == hi_row_ff) begin
               state_in = S_OUT;
            end
         end

         S_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tdata_in               = '0;
               rsp_tdata_in[1:0]          = status_ff;
               rsp_tdata_in[RSP_OCC_BIT]  = occ_ff;
               rsp_tdata_in[RSP_LOC_BIT]  = loc_ff;
               rsp_tdata_in[RSP_FREE_BIT] = free_ff;
               rsp_tvalid_in              = 1'b1;
               state_in                   = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         row_ff        <= '0;
         rmw_vld_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_ff        <= row_in;
         rmw_vld_ff    <= rmw_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      cmd_ff      <= cmd_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cz_ff       <= cz_in;
      gflag_ff    <= gflag_in;
      bflag_ff    <= bflag_in;
      qx_ff       <= qx_in;
      qy_ff       <= qy_in;
      negx_ff     <= negx_in;
      negy_ff     <= negy_in;
      cellx_ff    <= cellx_in;
      celly_ff    <= celly_in;
      iy_ff       <= iy_in;
      hi_row_ff   <= hi_row_in;
      and_mask_ff <= and_mask_in;
      or_mask_ff  <= or_mask_in;
      status_ff   <= status_in;
      occ_ff      <= occ_in;
      loc_ff      <= loc_in;
      free_ff     <= free_in;
      rmw_row_ff  <= rmw_row_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

// ===== hdl/logi_checker.sv =====
// ----------------------------------------------------------------------------
// logi_checker
// Port-level checks of the local obstacle grid inflation unit, bound to
// the top level.
// ----------------------------------------------------------------------------
module logi_checker
   import logi_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic [RSP_W-1:0] rsp_tdata,
   input logic             rsp_tvalid,
   input logic             rsp_tready
);

   // no result word right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word valid after reset");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed");

   // one command in flight: input closes after an accepted word
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input open while a command is in progress");

   // query flags agree with each other
   a_flags_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[RSP_LOC_BIT] || rsp_tdata[RSP_OCC_BIT])
                     && !(rsp_tdata[RSP_FREE_BIT] && rsp_tdata[RSP_OCC_BIT]))
      else $error("inconsistent query flags");

   // a failed command reports no flags
   a_fail_no_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] != ST_DONE) |->
         !rsp_tdata[RSP_OCC_BIT] && !rsp_tdata[RSP_LOC_BIT] && !rsp_tdata[RSP_FREE_BIT])
      else $error("flags set on a failed command");

endmodule

bind local_obstacle_grid_inflation_unit logi_checker u_logi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
